// ===== hdl/lfucp_pkg.sv =====
// shared constants, types and entry-store commands for the lfu cache policy block
`timescale 1ns / 1ps

package lfucp_pkg;

  // sizes
  localparam int ENTRIES    = 16;
  localparam int COUNT_BITS = 16;
  localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int RANK_W     = IDX_W;
  localparam int FILL_W     = $clog2(ENTRIES + 1);
  localparam int CAP_W      = 5;
  localparam int CMP_W      = (FILL_W > CAP_W) ? FILL_W : CAP_W;
  localparam int KEY_W      = 32;
  localparam int DATA_W     = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [RANK_W-1:0]     rank_t;
  typedef logic [FILL_W-1:0]     fill_t;
  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [CAP_W-1:0]      cap_t;
  typedef logic [CMP_W-1:0]      cmp_t;

  // update applied to the entry store at the addressed slot
  typedef enum logic [1:0] {
    ENT_NOP,
    ENT_BUMP,
    ENT_REPLACE,
    ENT_INSERT
  } ent_op_e;

  typedef struct packed {
    ent_op_e                  op;
    logic                     wr_value;
    logic signed [KEY_W-1:0]  key;
    logic signed [DATA_W-1:0] value;
  } ent_cmd_t;

  typedef struct packed {
    logic                     valid;
    logic signed [KEY_W-1:0]  key;
    logic signed [DATA_W-1:0] value;
    count_t                   count;
    rank_t                    rank;
  } ent_rd_t;

endpackage

// ===== hdl/lfucp_if.sv =====
// request and response channel interfaces of the lfu cache policy block
`timescale 1ns / 1ps

interface lfucp_req_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   mode;
  logic signed [lfucp_pkg::KEY_W-1:0]     key;
  logic signed [lfucp_pkg::DATA_W-1:0]    value;

  modport source (output valid, output mode, output key, output value, input ready);
  modport sink   (input valid, input mode, input key, input value, output ready);
endinterface

interface lfucp_rsp_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   hit;
  logic signed [lfucp_pkg::DATA_W-1:0]    read_value;

  modport source (output valid, output hit, output read_value, input ready);
  modport sink   (input valid, input hit, input read_value, output ready);
endinterface

// ===== hdl/lfu_cache_policy_top.sv =====
// top level of the lfu cache policy block: sequencer, shared scan compare and channels
`timescale 1ns / 1ps
//
// Key-value store of ENTRIES slots with least-frequently-used replacement and
// least-recently-used tie break.
// req_i carries one get (mode 0) or put (mode 1) beat with key and value;
// rsp_o returns exactly one beat per request with hit and read_value.
// A beat is taken when valid and ready are both high.
// cfg_we_i/cfg_wdata_i write cache_capacity; write it only while idle.
// Each request walks all ENTRIES slots through one key and one count/rank
// comparator, one slot per cycle, then updates the chosen slot in an apply
// state. No new request is taken while one is scanned or applied; ready
// returns once the apply state hands its result to the output register.
// A finished response waits in an output register; the next request is taken
// and scanned meanwhile, and its update waits until that register is free.
// Reset clears valid bits, the fill count and sets the capacity to 16.
//
module lfu_cache_policy_top (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  lfucp_req_if.sink             req_i,
  lfucp_rsp_if.source           rsp_o,
  input  logic                  cfg_we_i,
  input  logic [lfucp_pkg::CAP_W-1:0] cfg_wdata_i
);
  import lfucp_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY
  } state_e;

  state_e                   state_q;
  idx_t                     idx_q;
  logic                     mode_q;
  logic signed [KEY_W-1:0]  key_q;
  logic signed [DATA_W-1:0] value_q;
  logic                     mfound_q;
  idx_t                     mslot_q;
  logic                     vfound_q;
  idx_t                     vslot_q;
  count_t                   vcount_q;
  rank_t                    vrank_q;
  logic                     ffound_q;
  idx_t                     fslot_q;
  logic                     rsp_vld_q;
  logic                     hit_q;
  logic signed [DATA_W-1:0] rdval_q;
  cap_t                     cap_q;

  ent_rd_t  rd;
  ent_cmd_t cmd;
  fill_t    filled;

  logic     m_hit;
  logic     v_take;
  logic     f_take;
  logic     scan_last;
  logic     cap_zero;
  logic     is_full;
  cmp_t     cap_ext;
  cmp_t     cap_eff;
  idx_t     pick_slot;
  logic     apply_go;
  logic     res_hit;
  logic signed [DATA_W-1:0] res_val;

  lfucp_entries u_entries (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .idx_i    (idx_q),
    .cmd_i    (cmd),
    .rd_o     (rd),
    .filled_o (filled)
  );

  // capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  // effective capacity and fill check
  assign cap_ext  = CMP_W'(cap_q);
  assign cap_eff  = (cap_ext > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : cap_ext;
  assign cap_zero = (cap_q == '0);
  assign is_full  = (CMP_W'(filled) >= cap_eff);

  // shared compare unit: key match, victim order and first free slot
  assign m_hit  = rd.valid && (rd.key == key_q) && !mfound_q;
  assign v_take = rd.valid && (!vfound_q || (rd.count < vcount_q) ||
                  ((rd.count == vcount_q) && (rd.rank > vrank_q)));
  assign f_take = !rd.valid && !ffound_q;
  assign scan_last = (idx_q == IDX_W'(ENTRIES - 1));

  // slot the update phase works on, including the last scanned slot
  always_comb begin
    if (m_hit || mfound_q) begin
      pick_slot = m_hit ? idx_q : mslot_q;
    end else if (is_full) begin
      pick_slot = v_take ? idx_q : vslot_q;
    end else begin
      pick_slot = f_take ? idx_q : fslot_q;
    end
  end

  // update command and result for the item in hand
  assign apply_go = (state_q == ST_APPLY) && (!rsp_vld_q || rsp_o.ready);

  always_comb begin
    cmd.op       = ENT_NOP;
    cmd.wr_value = 1'b0;
    cmd.key      = key_q;
    cmd.value    = value_q;
    res_hit      = 1'b0;
    res_val      = '0;
    if (apply_go) begin
      if (!mode_q) begin
        if (mfound_q) begin
          cmd.op  = ENT_BUMP;
          res_hit = 1'b1;
          res_val = rd.value;
        end
      end else if (!cap_zero) begin
        if (mfound_q) begin
          cmd.op       = ENT_BUMP;
          cmd.wr_value = 1'b1;
          res_hit      = 1'b1;
        end else if (is_full) begin
          if (vfound_q) begin
            cmd.op = ENT_REPLACE;
          end
        end else if (ffound_q) begin
          cmd.op = ENT_INSERT;
        end
      end
    end
  end

  // sequencer with registered response
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      idx_q     <= '0;
      mode_q    <= 1'b0;
      key_q     <= '0;
      value_q   <= '0;
      mfound_q  <= 1'b0;
      mslot_q   <= '0;
      vfound_q  <= 1'b0;
      vslot_q   <= '0;
      vcount_q  <= '0;
      vrank_q   <= '0;
      ffound_q  <= 1'b0;
      fslot_q   <= '0;
      rsp_vld_q <= 1'b0;
      hit_q     <= 1'b0;
      rdval_q   <= '0;
    end else begin
      // drained beat, unless a new result replaces it in the same cycle
      if (rsp_vld_q && rsp_o.ready && !apply_go) begin
        rsp_vld_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (req_i.valid) begin
            mode_q   <= req_i.mode;
            key_q    <= req_i.key;
            value_q  <= req_i.value;
            idx_q    <= '0;
            mfound_q <= 1'b0;
            vfound_q <= 1'b0;
            ffound_q <= 1'b0;
            state_q  <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (m_hit) begin
            mfound_q <= 1'b1;
            mslot_q  <= idx_q;
          end
          if (v_take) begin
            vfound_q <= 1'b1;
            vslot_q  <= idx_q;
            vcount_q <= rd.count;
            vrank_q  <= rd.rank;
          end
          if (f_take) begin
            ffound_q <= 1'b1;
            fslot_q  <= idx_q;
          end
          if (scan_last) begin
            idx_q   <= pick_slot;
            state_q <= ST_APPLY;
          end else begin
            idx_q <= idx_q + idx_t'(1);
          end
        end
        ST_APPLY: begin
          if (apply_go) begin
            rsp_vld_q <= 1'b1;
            hit_q     <= res_hit;
            rdval_q   <= res_val;
            state_q   <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // channel outputs
  assign req_i.ready      = (state_q == ST_IDLE);
  assign rsp_o.valid      = rsp_vld_q;
  assign rsp_o.hit        = hit_q;
  assign rsp_o.read_value = rdval_q;

endmodule

// ===== hdl/lfucp_entries.sv =====
// entry store: valid bits, keys, values, use counts and recency rank lanes
`timescale 1ns / 1ps

module lfucp_entries (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lfucp_pkg::idx_t     idx_i,
  input  lfucp_pkg::ent_cmd_t cmd_i,
  output lfucp_pkg::ent_rd_t  rd_o,
  output lfucp_pkg::fill_t    filled_o
);
  import lfucp_pkg::*;

  logic                     valid_q [ENTRIES];
  logic                     valid_d [ENTRIES];
  logic signed [KEY_W-1:0]  key_q   [ENTRIES];
  logic signed [DATA_W-1:0] value_q [ENTRIES];
  count_t                   count_q [ENTRIES];
  rank_t                    rank_q  [ENTRIES];
  rank_t                    rank_d  [ENTRIES];
  fill_t                    filled_q;
  fill_t                    filled_d;
  rank_t                    old_rank;
  count_t                   count_inc;

  // single read port at the sequencer address
  assign rd_o.valid = valid_q[idx_i];
  assign rd_o.key   = key_q[idx_i];
  assign rd_o.value = value_q[idx_i];
  assign rd_o.count = count_q[idx_i];
  assign rd_o.rank  = rank_q[idx_i];
  assign filled_o   = filled_q;

  assign old_rank  = rank_q[idx_i];
  assign count_inc = (count_q[idx_i] == '1) ? count_q[idx_i] : count_q[idx_i] + count_t'(1);

  // recency lanes: bump/replace compare to the touched slot; insert ages the rest
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      rank_d[i]  = rank_q[i];
      valid_d[i] = valid_q[i];
      case (cmd_i.op)
        ENT_BUMP, ENT_REPLACE: begin
          if (idx_i == IDX_W'(i)) begin
            rank_d[i] = '0;
          end else if (valid_q[i] && (rank_q[i] < old_rank)) begin
            rank_d[i] = rank_q[i] + rank_t'(1);
          end
        end
        ENT_INSERT: begin
          if (idx_i == IDX_W'(i)) begin
            rank_d[i]  = '0;
            valid_d[i] = 1'b1;
          end else if (valid_q[i]) begin
            rank_d[i] = rank_q[i] + rank_t'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // fill count follows inserts
  always_comb begin
    filled_d = filled_q;
    if (cmd_i.op == ENT_INSERT) begin
      filled_d = filled_q + fill_t'(1);
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filled_q <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        valid_q[i] <= 1'b0;
      end
    end else begin
      filled_q <= filled_d;
      for (int i = 0; i < ENTRIES; i++) begin
        valid_q[i] <= valid_d[i];
      end
    end
  end

  // entry payload, written only at the addressed slot; rank lanes update in every slot
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < ENTRIES; i++) begin
      rank_q[i] <= rank_d[i];
    end
    case (cmd_i.op)
      ENT_BUMP: begin
        count_q[idx_i] <= count_inc;
        if (cmd_i.wr_value) begin
          value_q[idx_i] <= cmd_i.value;
        end
      end
      ENT_REPLACE, ENT_INSERT: begin
        key_q[idx_i]   <= cmd_i.key;
        value_q[idx_i] <= cmd_i.value;
        count_q[idx_i] <= count_t'(1);
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== hdl/lfucp_checker.sv =====
// port-level checker for the lfu cache policy top level, with its bind
`timescale 1ns / 1ps

module lfucp_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                req_valid_i,
  input logic                                req_ready_i,
  input logic                                rsp_valid_i,
  input logic                                rsp_ready_i,
  input logic                                rsp_hit_i,
  input logic signed [lfucp_pkg::DATA_W-1:0] rsp_read_value_i
);
  import lfucp_pkg::*;

  logic       req_fire;
  logic       rsp_fire;
  logic [1:0] pending_q;
  logic [1:0] pending_d;

  assign req_fire = req_valid_i && req_ready_i;
  assign rsp_fire = rsp_valid_i && rsp_ready_i;

  // requests taken but not yet answered
  always_comb begin
    pending_d = pending_q;
    if (req_fire && !rsp_fire) begin
      pending_d = pending_q + 2'd1;
    end else if (!req_fire && rsp_fire) begin
      pending_d = pending_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

  // busy right after taking a request
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> !req_ready_i)
    else $error("request taken while previous one still scanning");

  // a miss never carries data
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_hit_i) |-> (rsp_read_value_i == '0))
    else $error("miss response with nonzero read value");

  // every response answers a taken request
  a_rsp_has_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_fire |-> (pending_q != 2'd0))
    else $error("response beat without an open request");

  // at most one finished response waits while a new request enters
  a_req_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |-> (pending_q <= 2'd1))
    else $error("request taken with two requests open");

  // stalled response holds its payload
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_ready_i) |=>
      (rsp_valid_i && $stable(rsp_hit_i) && $stable(rsp_read_value_i)))
    else $error("stalled response changed");

endmodule

bind lfu_cache_policy_top lfucp_checker u_lfucp_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .req_valid_i      (req_i.valid),
  .req_ready_i      (req_i.ready),
  .rsp_valid_i      (rsp_o.valid),
  .rsp_ready_i      (rsp_o.ready),
  .rsp_hit_i        (rsp_o.hit),
  .rsp_read_value_i (rsp_o.read_value)
);

// ===== bench/lfu_cache_policy_top_tb.sv =====
// self-checking bench for the lfu cache policy block: get/put traffic checked against a shadow cache
`timescale 1ns / 1ps

module lfu_cache_policy_top_tb;
  import lfucp_pkg::*;

  localparam logic MODE_GET      = 1'b0;
  localparam logic MODE_PUT      = 1'b1;
  localparam int   STALL_MAX     = 4;
  localparam int   QUIET_LIMIT   = 2000;
  localparam int   SETTLE_CYCLES = ENTRIES + 4;
  localparam int   BURST_GETS    = 20;
  localparam int   PHASE_ITEMS   = 110;
  localparam int   NUM_PHASES    = 8;
  localparam int   POOL_SIZE     = 24;
  localparam int   REPORT_MAX    = 30;

  typedef struct {
    logic                     mode;
    logic signed [KEY_W-1:0]  key;
    logic signed [DATA_W-1:0] value;
  } access_t;

  typedef struct {
    logic                     hit;
    logic signed [DATA_W-1:0] read_value;
  } reply_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  cap_t cfg_wdata_i;

  lfucp_req_if req_ch();
  lfucp_rsp_if rsp_ch();

  lfu_cache_policy_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_ch),
    .rsp_o       (rsp_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // shadow copy of the cache contents
  bit                       slot_used [ENTRIES];
  logic signed [KEY_W-1:0]  slot_key  [ENTRIES];
  logic signed [DATA_W-1:0] slot_data [ENTRIES];
  count_t                   slot_uses [ENTRIES];
  int                       slot_age  [ENTRIES];
  int                       slots_filled;
  cap_t                     capacity;

  access_t pending_q[$];
  reply_t  reply_q[$];
  access_t in_flight;
  bit      steady;
  int      mismatches;
  int      quiet_cycles;
  int      gap_left;
  int      stall_left;

  // move a slot to the front of the recency order
  function automatic void make_recent(int s);
    int old_age;
    old_age = slot_age[s];
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot_used[i] && i != s && slot_age[i] < old_age) slot_age[i]++;
    end
    slot_age[s] = 0;
  endfunction

  // one more use of a slot, count saturates
  function automatic void count_use(int s);
    if (slot_uses[s] != '1) slot_uses[s]++;
    make_recent(s);
  endfunction

  function automatic int find_slot(logic signed [KEY_W-1:0] k);
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot_used[i] && slot_key[i] == k) return i;
    end
    return -1;
  endfunction

  // apply one get or put to the shadow cache and return its response
  function automatic reply_t cache_access(access_t a);
    reply_t r;
    int     s;
    int     lim;
    r.hit        = 1'b0;
    r.read_value = '0;
    lim = (capacity > ENTRIES) ? ENTRIES : int'(capacity);
    s   = find_slot(a.key);
    if (a.mode == MODE_GET) begin
      if (s >= 0) begin
        r.hit        = 1'b1;
        r.read_value = slot_data[s];
        count_use(s);
      end
      return r;
    end
    if (lim == 0) return r;
    if (s >= 0) begin
      r.hit        = 1'b1;
      slot_data[s] = a.value;
      count_use(s);
      return r;
    end
    if (slots_filled >= lim) begin
      // evict lowest count, oldest among equals
      s = -1;
      for (int i = 0; i < ENTRIES; i++) begin
        if (slot_used[i] && (s < 0 || slot_uses[i] < slot_uses[s] ||
            (slot_uses[i] == slot_uses[s] && slot_age[i] > slot_age[s]))) s = i;
      end
      if (s < 0) return r;
      make_recent(s);
    end else begin
      // first free slot, everyone else ages by one
      s = -1;
      for (int i = 0; i < ENTRIES; i++) begin
        if (!slot_used[i] && s < 0) s = i;
      end
      if (s < 0) return r;
      for (int i = 0; i < ENTRIES; i++) begin
        if (slot_used[i]) slot_age[i]++;
      end
      slot_used[s] = 1'b1;
      slot_age[s]  = 0;
      slots_filled++;
    end
    slot_key[s]  = a.key;
    slot_data[s] = a.value;
    slot_uses[s] = count_t'(1);
    return r;
  endfunction

  task automatic queue_access(logic mode, logic signed [KEY_W-1:0] key,
                              logic signed [DATA_W-1:0] value);
    access_t a;
    a.mode  = mode;
    a.key   = key;
    a.value = value;
    pending_q.push_back(a);
  endtask

  task automatic report_field(string field, logic signed [DATA_W-1:0] want,
                              logic signed [DATA_W-1:0] got);
    mismatches++;
    if (mismatches <= REPORT_MAX)
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
  endtask

  // wait until every beat has gone through, then let the block settle
  task automatic wait_idle();
    do @(posedge clk_i);
    while (pending_q.size() != 0 || req_ch.valid || reply_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_capacity(cap_t c);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= c;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    capacity = c;
  endtask

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_ch.valid <= 1'b0;
      req_ch.mode  <= MODE_GET;
      req_ch.key   <= '0;
      req_ch.value <= '0;
      gap_left = 0;
    end else begin
      if (req_ch.valid && req_ch.ready) reply_q.push_back(cache_access(in_flight));
      if (!req_ch.valid || req_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          req_ch.valid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          in_flight = pending_q.pop_front();
          req_ch.valid <= 1'b1;
          req_ch.mode  <= in_flight.mode;
          req_ch.key   <= in_flight.key;
          req_ch.value <= in_flight.value;
          gap_left = steady ? 0 : $urandom_range(0, STALL_MAX);
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // response monitor with random back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    reply_t want;
    if (!rst_ni) begin
      rsp_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (reply_q.size() == 0) begin
          mismatches++;
          $display("%0t ns: response beat with nothing expected, actual hit %0b value %0d",
                   $time, rsp_ch.hit, rsp_ch.read_value);
        end else begin
          want = reply_q.pop_front();
          if (rsp_ch.hit !== want.hit) report_field("hit", want.hit, rsp_ch.hit);
          if (rsp_ch.read_value !== want.read_value)
            report_field("read_value", want.read_value, rsp_ch.read_value);
        end
        stall_left = steady ? 0 : $urandom_range(0, STALL_MAX);
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk_i) begin
    if (!rst_ni || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t ns: no beat for %0d cycles", $time, QUIET_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // stimulus
  initial begin
    logic signed [KEY_W-1:0] key_pool [POOL_SIZE];
    cap_t                    phase_caps [NUM_PHASES];
    int                      span;
    logic signed [KEY_W-1:0] k;
    rst_ni       <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_wdata_i  <= '0;
    capacity     = CAP_RESET;
    steady       = 1'b0;
    mismatches   = 0;
    quiet_cycles = 0;
    phase_caps   = '{5'd1, 5'd31, 5'd0, 5'd7, 5'd16, 5'd2, 5'd20, 5'd0};
    phase_caps[NUM_PHASES-1] = cap_t'($urandom_range(0, 31));
    key_pool[0] = 32'sh8000_0000;
    key_pool[1] = 32'sh7fff_ffff;
    key_pool[2] = -32'sd1;
    key_pool[3] = 32'sd0;
    for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extreme keys and values, hits, misses, overwrite, fill and evict
    queue_access(MODE_PUT, 32'sh8000_0000, 32'sh7fff_ffff);
    queue_access(MODE_PUT, 32'sh7fff_ffff, 32'sh8000_0000);
    queue_access(MODE_PUT, -32'sd1, 32'sd0);
    queue_access(MODE_PUT, 32'sd0, -32'sd1);
    queue_access(MODE_GET, 32'sh8000_0000, 32'sd0);
    queue_access(MODE_GET, 32'sh7fff_ffff, -32'sd1);
    queue_access(MODE_GET, -32'sd1, 32'sd0);
    queue_access(MODE_GET, 32'sd0, 32'sd0);
    queue_access(MODE_GET, 32'sh1234_5678, 32'sd0);
    queue_access(MODE_PUT, -32'sd1, 32'sh5a5a_a5a5);
    for (int j = 0; j < 12; j++) queue_access(MODE_PUT, 32'sh100 + j, $urandom);
    queue_access(MODE_PUT, 32'sh7000_0000, $urandom);
    queue_access(MODE_GET, 32'sh100, 32'sd0);
    queue_access(MODE_GET, 32'sh101, 32'sd0);
    wait_idle();

    // repeated gets on one key, back to back
    steady = 1'b1;
    repeat (BURST_GETS) queue_access(MODE_GET, 32'sh7fff_ffff, $urandom);
    wait_idle();
    steady = 1'b0;

    // random phases over several capacities, including zero and above the size
    for (int p = 0; p < NUM_PHASES; p++) begin
      set_capacity(phase_caps[p]);
      steady = (p == 4);
      span   = $urandom_range(2, POOL_SIZE);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        k = ($urandom_range(0, 4) != 0) ? key_pool[$urandom_range(0, span - 1)] : $urandom;
        queue_access(logic'($urandom_range(0, 1)), k, $urandom);
        // sender holds off mid-phase until every response is back
        if (n == PHASE_ITEMS / 2) wait_idle();
      end
      wait_idle();
    end

    if (mismatches == 0 && reply_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
